// ----- hdl/url_percent_decoder_defines.svh -----
// assertion macros for the url percent decoder
// used by the top level only, no other dependencies
`ifndef URL_PERCENT_DECODER_DEFINES_SVH
`define URL_PERCENT_DECODER_DEFINES_SVH

`ifndef ASSERT_OFF
`define URLDEC_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("%m: assertion failed");
`define URLDEC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: assertion failed");
`else
`define URLDEC_ASSERT(label, clk, rst_n, prop)
`define URLDEC_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- hdl/urldec_pkg.sv -----
// types, constants and hex helper for the url percent decoder
// no dependencies
`default_nettype none

package urldec_pkg;

  localparam logic [7:0] CH_PLUS     = 8'h2B;
  localparam logic [7:0] CH_PERCENT  = 8'h25;
  localparam logic [7:0] CH_QUESTION = 8'h3F;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_ZERO     = 8'h30;
  localparam logic [7:0] CH_NINE     = 8'h39;
  localparam logic [7:0] CH_UP_A     = 8'h41;
  localparam logic [7:0] CH_UP_F     = 8'h46;
  localparam logic [7:0] CH_LO_A     = 8'h61;
  localparam logic [7:0] CH_LO_F     = 8'h66;
  localparam int unsigned HEX_ALPHA_OFS = 10;

  localparam logic [1:0] PH_PLAIN = 2'd0;
  localparam logic [1:0] PH_PCT   = 2'd1;
  localparam logic [1:0] PH_DIGIT = 2'd2;

  localparam int unsigned MAX_RES    = 3;
  localparam int unsigned RES_CNT_W  = 2;
  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned FIFO_PTR_W = 1;
  localparam int unsigned FIFO_CNT_W = 2;

  typedef struct packed {
    logic [7:0] in_char;
    logic       in_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       run_end;
    logic       stream_end;
  } out_item_t;

  typedef struct packed {
    logic [MAX_RES-1:0][7:0] chars;
    logic [RES_CNT_W-1:0]    count;
    logic                    last;
  } req_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  function automatic hex_t hex_decode(logic [7:0] c);
    hex_t r;
    r.ok  = 1'b1;
    r.val = c[3:0];
    if (c >= CH_ZERO && c <= CH_NINE) begin
      r.val = c[3:0];
    end else if ((c >= CH_UP_A && c <= CH_UP_F) || (c >= CH_LO_A && c <= CH_LO_F)) begin
      r.val = 4'(HEX_ALPHA_OFS) + {1'b0, c[2:0]} - 4'd1;
    end else begin
      r.ok = 1'b0;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/url_percent_decoder.sv -----
// url percent decoder: one encoded byte per cycle in, one decoded byte per cycle out, while no stall holds the flow
// an accepted byte is registered in the request queue, and each of its results in the output register
// throughput: one byte per cycle while each byte gives at most one result and nothing
// stalls; a byte with two or three results holds the output while the back part emits
// one result per cycle from the two-entry request queue
// reset: escape phase to plain text, queue and output register emptied
`default_nettype none
`include "url_percent_decoder_defines.svh"

module url_percent_decoder import urldec_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire in_item_t in_data_i,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output out_item_t     out_data_o
);

  logic       push, pop;
  req_t       push_req, head;
  fifo_stat_t fifo_stat;

  urldec_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .fifo_stat_i (fifo_stat),
    .push_o      (push),
    .push_req_o  (push_req)
  );

  urldec_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_req_i (push_req),
    .pop_i      (pop),
    .head_o     (head),
    .stat_o     (fifo_stat)
  );

  urldec_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .fifo_stat_i (fifo_stat),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  `URLDEC_ASSERT(a_fifo_stat, clk_i, rst_ni, !(fifo_stat.full && fifo_stat.empty))
  `URLDEC_ASSERT_IMPL(a_pop_nonempty, clk_i, rst_ni, pop, !fifo_stat.empty)
  `URLDEC_ASSERT_IMPL(a_push_not_full, clk_i, rst_ni, push, !fifo_stat.full)
  `URLDEC_ASSERT_IMPL(a_stream_end_run_end, clk_i, rst_ni,
                      out_valid_o && out_data_o.stream_end, out_data_o.run_end)

endmodule

`default_nettype wire

// ----- hdl/urldec_front.sv -----
// front part: accepts bytes, tracks escape phase, builds result requests
// depends on urldec_pkg
`default_nettype none

module urldec_front import urldec_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire in_item_t   in_data_i,
  input  wire fifo_stat_t fifo_stat_i,
  output logic            push_o,
  output req_t            push_req_o
);

  logic [1:0] phase_q, phase_d;
  logic [7:0] held_q, held_d;
  logic       accept;
  logic [7:0] c;
  logic       e;
  hex_t       hc, hh;
  logic       p_emit, p_pct;
  logic [7:0] p_char;
  logic       h_emit;
  logic [7:0] h_char;
  req_t       req;

  assign c  = in_data_i.in_char;
  assign e  = in_data_i.in_end;
  assign hc = hex_decode(c);
  assign hh = hex_decode(held_q);

  assign in_stall_o = fifo_stat_i.full;
  assign accept     = in_valid_i && !in_stall_o;

  // plain text handling of the new byte
  always_comb begin
    p_emit = 1'b1;
    p_pct  = 1'b0;
    p_char = c;
    if (c == CH_PLUS) begin
      p_char = CH_SPACE;
    end else if (c == CH_PERCENT) begin
      if (e) begin
        p_char = CH_QUESTION;
      end else begin
        p_emit = 1'b0;
        p_pct  = 1'b1;
      end
    end
  end

  // plain text handling of the held digit
  assign h_emit = held_q != CH_PERCENT;
  assign h_char = (held_q == CH_PLUS) ? CH_SPACE : held_q;

  always_comb begin
    req.chars = '0;
    req.count = '0;
    req.last  = e;
    phase_d   = phase_q;
    held_d    = held_q;
    case (phase_q)
      PH_PCT: begin
        if (hc.ok && !e) begin
          phase_d = PH_DIGIT;
          held_d  = c;
        end else begin
          req.chars[0] = CH_QUESTION;
          req.chars[1] = p_char;
          req.count    = p_emit ? RES_CNT_W'(2) : RES_CNT_W'(1);
          phase_d      = p_pct ? PH_PCT : PH_PLAIN;
        end
      end
      PH_DIGIT: begin
        if (hc.ok && hh.ok) begin
          req.chars[0] = {hh.val, hc.val};
          req.count    = RES_CNT_W'(1);
          phase_d      = PH_PLAIN;
        end else begin
          req.chars[0] = CH_QUESTION;
          if (h_emit) begin
            req.chars[1] = h_char;
            req.chars[2] = p_char;
            req.count    = p_emit ? RES_CNT_W'(3) : RES_CNT_W'(2);
          end else begin
            req.chars[1] = p_char;
            req.count    = p_emit ? RES_CNT_W'(2) : RES_CNT_W'(1);
          end
          phase_d = p_pct ? PH_PCT : PH_PLAIN;
        end
      end
      default: begin
        req.chars[0] = p_char;
        req.count    = p_emit ? RES_CNT_W'(1) : RES_CNT_W'(0);
        phase_d      = p_pct ? PH_PCT : PH_PLAIN;
      end
    endcase
    if (e) begin
      phase_d = PH_PLAIN;
    end
  end

  assign push_o     = accept && (req.count != '0);
  assign push_req_o = req;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_PLAIN;
      held_q  <= '0;
    end else if (accept) begin
      phase_q <= phase_d;
      held_q  <= held_d;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/urldec_fifo.sv -----
// short request queue between the front and back parts
// depends on urldec_pkg
`default_nettype none

module urldec_fifo import urldec_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  wire req_t  push_req_i,
  input  wire logic  pop_i,
  output req_t       head_o,
  output fifo_stat_t stat_o
);

  req_t                  entry_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [FIFO_CNT_W-1:0] cnt_q;

  assign head_o       = entry_q[rd_ptr_q];
  assign stat_o.full  = cnt_q == FIFO_CNT_W'(FIFO_DEPTH);
  assign stat_o.empty = cnt_q == '0;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_req_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + FIFO_CNT_W'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - FIFO_CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ----- hdl/urldec_back.sv -----
// back part: plays out the results of each request into the output register
// depends on urldec_pkg
`default_nettype none

module urldec_back import urldec_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire req_t       head_i,
  input  wire fifo_stat_t fifo_stat_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output out_item_t       out_data_o
);

  logic [RES_CNT_W-1:0] idx_q;
  logic                 out_valid_q;
  out_item_t            out_data_q;
  logic                 load;
  logic                 last_one;

  assign load     = !fifo_stat_i.empty && (!out_valid_q || !out_stall_i);
  assign last_one = idx_q == RES_CNT_W'(head_i.count - RES_CNT_W'(1));
  assign pop_o    = load && last_one;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        idx_q       <= last_one ? '0 : idx_q + RES_CNT_W'(1);
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_data_q.out_char   <= head_i.chars[idx_q];
      out_data_q.run_end    <= last_one;
      out_data_q.stream_end <= last_one && head_i.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

// ----- verif/url_percent_decoder_checker.sv -----
`timescale 1ns / 100ps
// checker for the url percent decoder: watches both channels, predicts decoded bytes
// from each accepted request and compares results in order; depends on urldec_pkg
module url_percent_decoder_checker import urldec_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  input  wire logic      in_stall_i,
  input  wire in_item_t  in_data_i,
  input  wire logic      out_valid_i,
  input  wire logic      out_stall_i,
  input  wire out_item_t out_data_i,
  output int             pending_o,
  output int             fail_count_o
);

  logic [1:0] esc_phase;
  logic [7:0] held_char;
  logic [7:0] emitted [MAX_RES];
  int         n_emitted;
  out_item_t  decoded_q [$];
  out_item_t  want;

  function automatic logic is_hex(logic [7:0] c);
    return (c >= CH_ZERO && c <= CH_NINE) || (c >= CH_UP_A && c <= CH_UP_F) ||
           (c >= CH_LO_A && c <= CH_LO_F);
  endfunction

  function automatic logic [3:0] hex_nibble(logic [7:0] c);
    return (c <= CH_NINE) ? c[3:0] : c[3:0] + 4'd9;
  endfunction

  function automatic void push_char(logic [7:0] c);
    if (n_emitted < MAX_RES) begin
      emitted[n_emitted] = c;
      n_emitted++;
    end
  endfunction

  function automatic void decode_plain(logic [7:0] c, logic fin);
    esc_phase = PH_PLAIN;
    if (c == CH_PLUS) begin
      push_char(CH_SPACE);
    end else if (c == CH_PERCENT) begin
      if (fin) begin
        push_char(CH_QUESTION);
      end else begin
        esc_phase = PH_PCT;
      end
    end else begin
      push_char(c);
    end
  endfunction

  function automatic void decode_request(in_item_t req);
    out_item_t  res;
    logic [7:0] c;
    logic       fin;
    c = req.in_char;
    fin = req.in_end;
    n_emitted = 0;
    case (esc_phase)
      PH_PCT: begin
        if (is_hex(c) && !fin) begin
          held_char = c;
          esc_phase = PH_DIGIT;
        end else begin
          push_char(CH_QUESTION);
          decode_plain(c, fin);
        end
      end
      PH_DIGIT: begin
        if (is_hex(c) && is_hex(held_char)) begin
          push_char({hex_nibble(held_char), hex_nibble(c)});
          esc_phase = PH_PLAIN;
        end else begin
          push_char(CH_QUESTION);
          decode_plain(held_char, 1'b0);
          decode_plain(c, fin);
        end
      end
      default: begin
        decode_plain(c, fin);
      end
    endcase
    if (fin) esc_phase = PH_PLAIN;
    for (int i = 0; i < n_emitted; i++) begin
      res.out_char = emitted[i];
      res.run_end = (i == n_emitted - 1);
      res.stream_end = res.run_end && fin;
      decoded_q.push_back(res);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_phase = PH_PLAIN;
      held_char = '0;
      decoded_q.delete();
      fail_count_o = 0;
    end else begin
      if (in_valid_i && !in_stall_i) decode_request(in_data_i);
      if (out_valid_i && !out_stall_i) begin
        if (decoded_q.size() == 0) begin
          if (fail_count_o < 10) begin
            $display("%0t: unexpected result char %h run_end %b stream_end %b", $realtime,
                     out_data_i.out_char, out_data_i.run_end, out_data_i.stream_end);
          end
          fail_count_o++;
        end else begin
          want = decoded_q.pop_front();
          if (want.out_char !== out_data_i.out_char || want.run_end !== out_data_i.run_end ||
              want.stream_end !== out_data_i.stream_end) begin
            if (fail_count_o < 10) begin
              $display("%0t: mismatch want char %h run_end %b stream_end %b, got %h %b %b",
                       $realtime, want.out_char, want.run_end, want.stream_end,
                       out_data_i.out_char, out_data_i.run_end, out_data_i.stream_end);
            end
            fail_count_o++;
          end
        end
      end
    end
    pending_o = decoded_q.size();
  end

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps
// testbench top for the url percent decoder: clock, reset, request stimulus and verdict
// depends on urldec_pkg, url_percent_decoder and url_percent_decoder_checker
module tb_top;
  import urldec_pkg::*;

  typedef logic [7:0] byte_q_t [$];

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int          N_RANDOM    = 360;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  int          pending;
  int          fail_count;
  int          items_sent;
  int          sender_idle_pct;
  int          recv_stall_pct;
  int unsigned cycle_count;

  url_percent_decoder u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  url_percent_decoder_checker u_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_data_i   (out_data),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** url_percent_decoder: FAILED **");
      $finish;
    end
  end

  function automatic logic [7:0] rand_hex();
    int k;
    k = $urandom_range(21);
    if (k < 10) return CH_ZERO + 8'(k);
    else if (k < 16) return CH_UP_A + 8'(k - 10);
    else return CH_LO_A + 8'(k - 16);
  endfunction

  function automatic logic [7:0] rand_non_hex();
    case ($urandom_range(3))
      0: return 8'($urandom_range(CH_ZERO - 1));
      1: return 8'($urandom_range(CH_UP_A - 1, CH_NINE + 1));
      2: return 8'($urandom_range(CH_LO_A - 1, CH_UP_F + 1));
      default: return 8'($urandom_range(255, CH_LO_F + 1));
    endcase
  endfunction

  task automatic send_request(input in_item_t req);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  task automatic send_bytes(input byte_q_t text);
    in_item_t req;
    foreach (text[i]) begin
      req.in_char = text[i];
      req.in_end = (i == text.size() - 1);
      send_request(req);
    end
  endtask

  task automatic send_text(input string s);
    byte_q_t text;
    for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
    send_bytes(text);
  endtask

  // mostly well-formed escapes, with broken and dangling ones mixed in
  task automatic send_random_string();
    byte_q_t text;
    int      kind;
    repeat ($urandom_range(6, 1)) begin
      kind = $urandom_range(99);
      if (kind < 25) begin
        text.push_back(8'($urandom_range(255)));
      end else if (kind < 35) begin
        text.push_back(CH_PLUS);
      end else if (kind < 75) begin
        text.push_back(CH_PERCENT);
        text.push_back(rand_hex());
        text.push_back(rand_hex());
      end else if (kind < 85) begin
        text.push_back(CH_PERCENT);
        text.push_back(rand_non_hex());
      end else if (kind < 93) begin
        text.push_back(CH_PERCENT);
        text.push_back(rand_hex());
        text.push_back(rand_non_hex());
      end else begin
        text.push_back(CH_PERCENT);
        if ($urandom_range(1)) text.push_back(rand_hex());
      end
    end
    send_bytes(text);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cycle_count = 0;
    items_sent = 0;
    sender_idle_pct = 34;
    recv_stall_pct = 62;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_request('{in_char: 8'h00, in_end: 1'b0});
    send_request('{in_char: 8'hFF, in_end: 1'b0});
    send_text("+");
    send_text("%41");
    send_text("%fF");
    send_text("%z");
    send_text("%4%");
    send_text("%%41");
    send_text("%");
    send_text("%7");
    send_text("%A+%00");
    drain();

    for (int p = 0; p < 3; p++) begin
      case (p)
        0: begin
          sender_idle_pct = 34;
          recv_stall_pct = 62;
        end
        1: begin
          sender_idle_pct = 62;
          recv_stall_pct = 34;
        end
        default: begin
          sender_idle_pct = 0;
          recv_stall_pct = 0;
        end
      endcase
      while (items_sent < 27 + (p + 1) * N_RANDOM / 3) send_random_string();
      drain();
    end

    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("** url_percent_decoder: PASSED **");
    end else begin
      $display("** url_percent_decoder: FAILED **");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/urldec_pkg.sv
hdl/urldec_front.sv
hdl/urldec_fifo.sv
hdl/urldec_back.sv
hdl/url_percent_decoder.sv
verif/url_percent_decoder_checker.sv
verif/tb_top.sv
